FILE: rtl/core/bgtr_pkg.sv
// ---------------------------------------------------------------------------
// bgtr_pkg: shared constants and types of the bilinear gray tile resampler
// Field widths, fixed-point formats, register indexes and the structs
// exchanged between the tap generators, the luma store and the blender.
// ---------------------------------------------------------------------------
`default_nettype none

package bgtr_pkg;

	// Default side of the square window store around the board.
	localparam int WINDOW_SIDE_DEF = 512;

	// Resample geometry. OUT_SIDE must stay a power of two: the tap position
	// is split into integer and fraction by bit position.
	localparam int OUT_SIDE  = 256;
	localparam int TILE_SIDE = 32;
	localparam int FRAC_W    = $clog2(2 * OUT_SIDE);
	localparam int WT_W      = FRAC_W + 1;
	localparam int TC_W      = $clog2(8 * TILE_SIDE);

	// Field and register widths.
	localparam int PIX_W  = 12;
	localparam int CH_W   = 8;
	localparam int ORG_W  = 12;
	localparam int SPAN_W = 9;
	localparam int IMG_W  = 13;
	localparam int TAP_W  = 13;
	localparam int LUMA_W = 24;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CIDX_W-1:0] CFG_BOARD_LEFT   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_BOARD_TOP    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_BOARD_SPAN_X = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_BOARD_SPAN_Y = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_SPAN_X = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_SPAN_Y = 3'd5;

	// Item kinds.
	localparam logic MODE_STORE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Luma weights in Q0.16; they sum to 65536.
	localparam logic [15:0] COEF_R = 16'd19595;
	localparam logic [15:0] COEF_G = 16'd38470;
	localparam logic [15:0] COEF_B = 16'd7471;

	// Division by 255: multiply by 65793 / 2^24, then one correction step.
	localparam int          LUMA_FULL    = 255;
	localparam int          DIV_MUL_W    = 17;
	localparam logic [16:0] DIV255_MUL   = 17'd65793;
	localparam int          DIV255_SHIFT = 24;

	// Taps and fraction along one axis.
	typedef struct packed {
		logic [TAP_W-1:0]  t0;
		logic [TAP_W-1:0]  t1;
		logic [FRAC_W-1:0] frac;
	} axis_tap_t;

	// Access request to the luma store; a write uses x0 and y0 only.
	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [TAP_W-1:0]  x0;
		logic [TAP_W-1:0]  x1;
		logic [TAP_W-1:0]  y0;
		logic [TAP_W-1:0]  y1;
		logic [LUMA_W-1:0] luma;
	} mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/bgtr_tap_gen.sv
// ---------------------------------------------------------------------------
// bgtr_tap_gen: bilinear tap generator for one axis
// Computes the center-aligned source position of an output coordinate in
// steps of 1/(2*OUT_SIDE), splits it into a floor tap and a fraction and
// clamps both taps to the image. Two register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module bgtr_tap_gen (
	input  logic                        clk,
	input  logic [bgtr_pkg::TC_W-1:0]   coord,
	input  logic [bgtr_pkg::ORG_W-1:0]  origin,
	input  logic [bgtr_pkg::SPAN_W-1:0] span,
	input  logic [bgtr_pkg::IMG_W-1:0]  img,
	output bgtr_pkg::axis_tap_t         tap
);
	import bgtr_pkg::*;

	localparam int N_W    = ORG_W + FRAC_W + 2;
	localparam int FL_W   = N_W - FRAC_W;
	localparam int PROD_W = TC_W + 1 + SPAN_W;

	logic [PROD_W-1:0]      prod;
	logic [N_W-1:0]         n_nxt;
	logic signed [N_W-1:0]  n_s1;
	logic signed [FL_W:0]   fl0;
	logic signed [FL_W:0]   fl1;
	logic [TAP_W-1:0]       hi;
	axis_tap_t              tap_s2;

	function automatic logic [TAP_W-1:0] clamp_tap(input logic signed [FL_W:0] v,
			input logic [TAP_W-1:0] lim);
		logic [TAP_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(FL_W + 1 - TAP_W){1'b0}}, lim})) begin
			r = lim;
		end else begin
			r = v[TAP_W-1:0];
		end
		return r;
	endfunction

	// Position numerator: 2*OUT_SIDE*origin + (2t+1)*span - OUT_SIDE.
	always_comb begin
		prod  = PROD_W'({coord, 1'b1}) * PROD_W'(span);
		n_nxt = N_W'({origin, {FRAC_W{1'b0}}}) + N_W'(prod) - N_W'(OUT_SIDE);
	end

	always_ff @(posedge clk) begin
		n_s1 <= $signed(n_nxt);
	end

	// The arithmetic shift is the floor; an image span of zero clamps to 0.
	always_comb begin
		fl0 = {n_s1[N_W-1], n_s1[N_W-1:FRAC_W]};
		fl1 = fl0 + (FL_W + 1)'(1);
		hi  = (img == '0) ? '0 : img - IMG_W'(1);
	end

	always_ff @(posedge clk) begin
		tap_s2.t0   <= clamp_tap(fl0, hi);
		tap_s2.t1   <= clamp_tap(fl1, hi);
		tap_s2.frac <= n_s1[FRAC_W-1:0];
	end

	assign tap = tap_s2;

endmodule

`default_nettype wire

FILE: rtl/core/bgtr_luma_store.sv
// ---------------------------------------------------------------------------
// bgtr_luma_store: banked window store of luma words
// Four single-port banks split by the parity of the window column and row,
// so taps of one sample hit distinct banks in one cycle unless clamped together.
// ---------------------------------------------------------------------------
`default_nettype none

module bgtr_luma_store #(
	parameter int WINDOW_SIDE = bgtr_pkg::WINDOW_SIDE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [bgtr_pkg::ORG_W-1:0]           board_left,
	input  logic [bgtr_pkg::ORG_W-1:0]           board_top,
	input  bgtr_pkg::mem_req_t                   req,
	output logic [3:0][bgtr_pkg::LUMA_W-1:0]     tap_luma
);
	import bgtr_pkg::*;

	localparam int HALF       = (WINDOW_SIDE + 1) / 2;
	localparam int BANK_DEPTH = HALF * HALF;
	localparam int BA_W       = $clog2(BANK_DEPTH);
	localparam int HC_W       = $clog2(HALF);
	localparam int WC_W       = $clog2(WINDOW_SIDE);
	localparam int SW         = TAP_W + 1;

	logic [WC_W:0]        cx0, cx1, cy0, cy1;
	logic [WC_W-1:0]      xsel, ysel;
	logic [1:0]           bsel;
	logic [3:0]           ok_nxt, we_nxt;
	logic [3:0][1:0]      bank_nxt;
	logic [3:0][BA_W-1:0] addr_nxt;

	logic [3:0]           we_s3, ok_s3, ok_s4;
	logic [3:0][1:0]      bank_s3, bank_s4;
	logic [BA_W-1:0]      addr_s3 [4];
	logic [LUMA_W-1:0]    wdata_s3;
	logic [LUMA_W-1:0]    rdata_s4 [4];

	// Returns {in_win, coordinate} of a tap relative to the window origin,
	// which sits one pixel above and left of the board corner.
	function automatic logic [WC_W:0] win_coord(input logic [TAP_W-1:0] v,
			input logic [ORG_W-1:0] org);
		logic signed [SW-1:0] w;
		logic                 in_win;
		w      = SW'(v) - SW'(org) + SW'(1);
		in_win = !w[SW-1] && ($unsigned(w) < SW'(WINDOW_SIDE));
		return {in_win, w[WC_W-1:0]};
	endfunction

	// Tap order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1).
	always_comb begin
		cx0 = win_coord(req.x0, board_left);
		cx1 = win_coord(req.x1, board_left);
		cy0 = win_coord(req.y0, board_top);
		cy1 = win_coord(req.y1, board_top);

		ok_nxt[0] = cx0[WC_W] & cy0[WC_W];
		ok_nxt[1] = cx1[WC_W] & cy0[WC_W];
		ok_nxt[2] = cx0[WC_W] & cy1[WC_W];
		ok_nxt[3] = cx1[WC_W] & cy1[WC_W];

		bank_nxt[0] = {cy0[0], cx0[0]};
		bank_nxt[1] = {cy0[0], cx1[0]};
		bank_nxt[2] = {cy1[0], cx0[0]};
		bank_nxt[3] = {cy1[0], cx1[0]};

		xsel = '0;
		ysel = '0;
		bsel = '0;
		for (int b = 0; b < 4; b++) begin
			bsel        = 2'(b);
			xsel        = (cx0[0] == bsel[0]) ? cx0[WC_W-1:0] : cx1[WC_W-1:0];
			ysel        = (cy0[0] == bsel[1]) ? cy0[WC_W-1:0] : cy1[WC_W-1:0];
			addr_nxt[b] = BA_W'(HC_W'(ysel >> 1) * HALF + HC_W'(xsel >> 1));
			we_nxt[b]   = req.wr & ok_nxt[0] & (bank_nxt[0] == bsel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s3 <= '0;
		end else begin
			we_s3 <= we_nxt;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3    <= ok_nxt;
		bank_s3  <= bank_nxt;
		wdata_s3 <= req.luma;
		for (int b = 0; b < 4; b++) begin
			addr_s3[b] <= addr_nxt[b];
		end
		ok_s4   <= ok_s3;
		bank_s4 <= bank_s3;
	end

	for (genvar gb = 0; gb < 4; gb++) begin : g_bank
		logic [LUMA_W-1:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			if (we_s3[gb]) begin
				mem[addr_s3[gb]] <= wdata_s3;
			end
			rdata_s4[gb] <= mem[addr_s3[gb]];
		end
	end

	// A tap outside the window reads as zero.
	always_comb begin
		for (int t = 0; t < 4; t++) begin
			tap_luma[t] = ok_s4[t] ? rdata_s4[bank_s4[t]] : '0;
		end
	end

	a_we_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(we_s3))
		else $error("luma store writes more than one bank");

	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd && req.wr))
		else $error("luma store request both reads and writes");

	a_x_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd |-> (req.x1 == req.x0 || {1'b0, req.x1} == {1'b0, req.x0} + SW'(1)))
		else $error("horizontal taps not adjacent, banks would collide");

	a_y_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd |-> (req.y1 == req.y0 || {1'b0, req.y1} == {1'b0, req.y0} + SW'(1)))
		else $error("vertical taps not adjacent, banks would collide");

endmodule

`default_nettype wire

FILE: rtl/core/bgtr_interp.sv
// ---------------------------------------------------------------------------
// bgtr_interp: bilinear blend and scaling to Q0.16
// Weighs the four tap lumas, rounds the sum divided by 255 and the squared
// fraction scale, and saturates. Five register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module bgtr_interp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [bgtr_pkg::FRAC_W-1:0]       fx,
	input  logic [bgtr_pkg::FRAC_W-1:0]       fy,
	input  logic [3:0][bgtr_pkg::LUMA_W-1:0]  tap_luma,
	output logic                              done,
	output logic [bgtr_pkg::OUT_W-1:0]        gray_sample
);
	import bgtr_pkg::*;

	localparam int TOP_W  = LUMA_W + WT_W;
	localparam int SUM_W  = TOP_W + WT_W;
	localparam int SHIFT  = 2 * FRAC_W;
	localparam int U_W    = SUM_W - SHIFT;
	localparam int Q_W    = OUT_W + 1;
	localparam int MP_W   = U_W + DIV_MUL_W;

	logic [WT_W-1:0]  wx0, wx1, wy0, wy1;
	logic [TOP_W-1:0] top_nxt, bot_nxt;
	logic [SUM_W-1:0] sum_nxt;
	logic [MP_W-1:0]  mp;
	logic [U_W-1:0]   rem;
	logic [Q_W-1:0]   q_fix;

	logic             vld_s5, vld_s6, vld_s7, vld_s8;
	logic [TOP_W-1:0] top_s5, bot_s5;
	logic [FRAC_W-1:0] fy_s5;
	logic [SUM_W-1:0] sum_s6;
	logic [U_W-1:0]   u_s7, u_s8;
	logic [Q_W-1:0]   q_est_s8;
	logic [OUT_W-1:0] gray_q;
	logic             done_q;

	// Horizontal blend of both tap rows.
	always_comb begin
		wx1     = WT_W'(fx);
		wx0     = WT_W'(2 * OUT_SIDE) - wx1;
		top_nxt = TOP_W'(tap_luma[0]) * TOP_W'(wx0) + TOP_W'(tap_luma[1]) * TOP_W'(wx1);
		bot_nxt = TOP_W'(tap_luma[2]) * TOP_W'(wx0) + TOP_W'(tap_luma[3]) * TOP_W'(wx1);
	end

	// Vertical blend.
	always_comb begin
		wy1     = WT_W'(fy_s5);
		wy0     = WT_W'(2 * OUT_SIDE) - wy1;
		sum_nxt = SUM_W'(top_s5) * SUM_W'(wy0) + SUM_W'(bot_s5) * SUM_W'(wy1);
	end

	// Quotient estimate is exact or one low; the remainder fixes it.
	always_comb begin
		mp    = MP_W'(u_s7) * MP_W'(DIV255_MUL);
		rem   = u_s8 - U_W'(q_est_s8) * U_W'(LUMA_FULL);
		q_fix = (rem >= U_W'(LUMA_FULL)) ? q_est_s8 + Q_W'(1) : q_est_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s5 <= in_valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			done_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		top_s5   <= top_nxt;
		bot_s5   <= bot_nxt;
		fy_s5    <= fy;
		sum_s6   <= sum_nxt;
		// Round half up, then drop the squared fraction scale.
		u_s7     <= U_W'((sum_s6 + (SUM_W'(LUMA_FULL) << (SHIFT - 1))) >> SHIFT);
		u_s8     <= u_s7;
		q_est_s8 <= Q_W'(mp >> DIV255_SHIFT);
		gray_q   <= q_fix[Q_W-1] ? {OUT_W{1'b1}} : q_fix[OUT_W-1:0];
	end

	assign done        = done_q;
	assign gray_sample = gray_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##5 done)
		else $error("sample lost in blend pipeline");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_valid, 5))
		else $error("result strobe without a sample");

	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> (rem < U_W'(2 * LUMA_FULL)))
		else $error("division by 255 estimate off by more than one");

endmodule

`default_nettype wire

FILE: rtl/core/bilinear_gray_tile_resampler.sv
// ---------------------------------------------------------------------------
// bilinear_gray_tile_resampler: luma window store and bilinear tile sampler
// Stores source pixels as luma around the board and returns bilinear,
// center-aligned samples of a tiled board resample as Q0.16 gray.
// ---------------------------------------------------------------------------
// A sample word shows on gray_sample with done high once it has passed the
// tap stages, the store read and the blend stages; a store word gives no result.
// Throughput: one word per cycle, stores and samples mixed freely; busy stays
// low since no stage, including the single memory access, ever holds a word back.
// Reset loads the configuration defaults and clears the pipeline valids; the
// luma store is not cleared; a location reads undefined until a store writes it.
`default_nettype none

module bilinear_gray_tile_resampler #(
	parameter int WINDOW_SIDE = bgtr_pkg::WINDOW_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_write,
	input  logic [bgtr_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [bgtr_pkg::CFG_W-1:0]    cfg_data,
	// Command side.
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [bgtr_pkg::PIX_W-1:0]    pixel_x,
	input  logic [bgtr_pkg::PIX_W-1:0]    pixel_y,
	input  logic [bgtr_pkg::CH_W-1:0]     red,
	input  logic [bgtr_pkg::CH_W-1:0]     green,
	input  logic [bgtr_pkg::CH_W-1:0]     blue,
	input  logic [5:0]                    tile_index,
	input  logic [4:0]                    tile_row,
	input  logic [4:0]                    tile_col,
	// Result side.
	output logic                          done,
	output logic [bgtr_pkg::OUT_W-1:0]    gray_sample
);
	import bgtr_pkg::*;

	// Configuration registers.
	logic [ORG_W-1:0]  board_left_q, board_top_q;
	logic [SPAN_W-1:0] board_span_x_q, board_span_y_q;
	logic [IMG_W-1:0]  image_span_x_q, image_span_y_q;

	// Front pipeline: the store word rides along the two tap stages so that
	// stores and sample reads meet the memory at the same stage.
	logic              accept;
	logic [TC_W-1:0]   tx, ty;
	logic [LUMA_W-1:0] luma_nxt;
	logic              vld_s1, vld_s2;
	logic              mode_s1, mode_s2;
	logic [PIX_W-1:0]  px_s1, py_s1, px_s2, py_s2;
	logic [LUMA_W-1:0] luma_s1, luma_s2;

	axis_tap_t         tap_x, tap_y;
	mem_req_t          mem_req;

	// Fractions and sample valid wait for the memory read.
	logic              smp_s3, smp_s4;
	logic [FRAC_W-1:0] fx_s3, fy_s3, fx_s4, fy_s4;

	logic [3:0][LUMA_W-1:0] tap_luma;

	// Every stage takes a new word each cycle, so nothing ever holds off.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// A write to an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_left_q   <= '0;
			board_top_q    <= '0;
			board_span_x_q <= SPAN_W'(256);
			board_span_y_q <= SPAN_W'(256);
			image_span_x_q <= IMG_W'(4096);
			image_span_y_q <= IMG_W'(4096);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BOARD_LEFT:   board_left_q   <= cfg_data[ORG_W-1:0];
				CFG_BOARD_TOP:    board_top_q    <= cfg_data[ORG_W-1:0];
				CFG_BOARD_SPAN_X: board_span_x_q <= cfg_data[SPAN_W-1:0];
				CFG_BOARD_SPAN_Y: board_span_y_q <= cfg_data[SPAN_W-1:0];
				CFG_IMAGE_SPAN_X: image_span_x_q <= cfg_data[IMG_W-1:0];
				CFG_IMAGE_SPAN_Y: image_span_y_q <= cfg_data[IMG_W-1:0];
				default: ;
			endcase
		end
	end

	// Board coordinates of the sample. Rank 0 lies at the bottom of the image,
	// so the rank is flipped to get the row from the top.
	always_comb begin
		tx = TC_W'(tile_index[2:0]) * TC_W'(TILE_SIDE) + TC_W'(tile_col);
		ty = TC_W'(3'd7 - tile_index[5:3]) * TC_W'(TILE_SIDE) + TC_W'(tile_row);
	end

	// Luma in Q8.16; the weights sum to one, so the result always fits.
	always_comb begin
		luma_nxt = LUMA_W'(red) * LUMA_W'(COEF_R) + LUMA_W'(green) * LUMA_W'(COEF_G)
			+ LUMA_W'(blue) * LUMA_W'(COEF_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			smp_s3 <= 1'b0;
			smp_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			smp_s3 <= mem_req.rd;
			smp_s4 <= smp_s3;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		px_s1   <= pixel_x;
		py_s1   <= pixel_y;
		luma_s1 <= luma_nxt;
		mode_s2 <= mode_s1;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		luma_s2 <= luma_s1;
		fx_s3   <= tap_x.frac;
		fy_s3   <= tap_y.frac;
		fx_s4   <= fx_s3;
		fy_s4   <= fy_s3;
	end

	bgtr_tap_gen u_tap_x (
		.clk    (clk),
		.coord  (tx),
		.origin (board_left_q),
		.span   (board_span_x_q),
		.img    (image_span_x_q),
		.tap    (tap_x)
	);

	bgtr_tap_gen u_tap_y (
		.clk    (clk),
		.coord  (ty),
		.origin (board_top_q),
		.span   (board_span_y_q),
		.img    (image_span_y_q),
		.tap    (tap_y)
	);

	// One request per cycle to the store. A store word uses its pixel as the
	// first tap. Since every word reaches the memory at the same stage, a
	// sample right behind a store sees the stored luma without forwarding.
	always_comb begin
		mem_req.rd   = vld_s2 && (mode_s2 == MODE_SAMPLE);
		mem_req.wr   = vld_s2 && (mode_s2 == MODE_STORE);
		mem_req.x0   = mem_req.wr ? TAP_W'(px_s2) : tap_x.t0;
		mem_req.x1   = mem_req.wr ? TAP_W'(px_s2) : tap_x.t1;
		mem_req.y0   = mem_req.wr ? TAP_W'(py_s2) : tap_y.t0;
		mem_req.y1   = mem_req.wr ? TAP_W'(py_s2) : tap_y.t1;
		mem_req.luma = luma_s2;
	end

	bgtr_luma_store #(
		.WINDOW_SIDE (WINDOW_SIDE)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.board_left (board_left_q),
		.board_top  (board_top_q),
		.req        (mem_req),
		.tap_luma   (tap_luma)
	);

	// Blend, divide by 255 with rounding, saturate; the result register
	// drives the ports for exactly one cycle per sample.
	bgtr_interp u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (smp_s4),
		.fx          (fx_s4),
		.fy          (fy_s4),
		.tap_luma    (tap_luma),
		.done        (done),
		.gray_sample (gray_sample)
	);

endmodule

`default_nettype wire
